// File: rtl/core/vhd_pkg.sv
`default_nettype none
// -----------------------------------------------------------------------------
// vhd_pkg
// Shared widths, register indexes and reset values of the volume downsampler.
// -----------------------------------------------------------------------------
package vhd_pkg;

  localparam int VOXEL_W    = 8;
  localparam int SUM_W      = 11;   // eight 8-bit voxels
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int EXT_W      = 13;   // holds any extent limit up to 4096
  localparam int DEPTH_W    = 16;
  localparam int OUT_DEPTH  = 4;    // output queue entries

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH  = 2'd3;

  // register reset values
  localparam logic [9:0]         RST_WIDTH  = 10'd512;
  localparam logic [9:0]         RST_HEIGHT = 10'd512;
  localparam logic [DEPTH_W-1:0] RST_DEPTH  = 16'd512;

endpackage

`default_nettype wire

// File: rtl/core/vhd_ifs.sv
`default_nettype none
// -----------------------------------------------------------------------------
// vhd_ifs
// Valid/ready channels of the downsampler: source voxels, output level, config.
// -----------------------------------------------------------------------------
interface vhd_voxel_if;
  logic                        valid;
  logic                        ready;
  logic [vhd_pkg::VOXEL_W-1:0] voxel_in;
  modport source (output valid, voxel_in, input ready);
  modport sink   (input valid, voxel_in, output ready);
endinterface

interface vhd_level_if;
  logic                        valid;
  logic                        ready;
  logic [vhd_pkg::VOXEL_W-1:0] voxel_out;
  logic                        final_voxel;
  modport source (output valid, voxel_out, final_voxel, input ready);
  modport sink   (input valid, voxel_out, final_voxel, output ready);
endinterface

interface vhd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [vhd_pkg::CFG_IDX_W-1:0]  reg_index;
  logic [vhd_pkg::CFG_DATA_W-1:0] data;
  modport source (output valid, reg_index, data, input ready);
  modport sink   (input valid, reg_index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/core/volume_halving_downsampler_top.sv
`default_nettype none
// -----------------------------------------------------------------------------
// volume_halving_downsampler_top
// One pyramid level of an 8-bit volume: even-voxel pick or 2x2x2 box mean.
// -----------------------------------------------------------------------------
// Source voxels arrive in raster order (x fastest, then y, then z), one beat
// per voxel, and one voxel is taken every clock cycle as long as the output
// side keeps up; an output beat follows its last source voxel via stage 1 and
// the queue. In nearest mode every voxel with all coordinates even is passed on
// (ceil(n/2) per axis). In average mode each 2x2x2 block is summed in a
// plane-sized sum RAM, one read-modify-write per voxel, and sum>>3 goes out
// with the block's last voxel (floor(n/2) per axis, a trailing odd column,
// row or slice is dropped). final_voxel marks the last beat of a volume and
// the coordinates wrap for the next one. The sum RAM needs no clearing pass:
// the first voxel of a block overwrites its entry. Extents of 0 count as 1,
// width and height saturate at MAX_WIDTH and MAX_HEIGHT. Any register write
// restarts the volume; write registers only while the block is idle.
// -----------------------------------------------------------------------------
module volume_halving_downsampler_top #(
  parameter int MAX_WIDTH  = 512,
  parameter int MAX_HEIGHT = 512
) (
  input wire logic  clk,
  input wire logic  rst,
  vhd_voxel_if.sink   voxel_stream,
  vhd_level_if.source level_stream,
  vhd_cfg_if.sink     cfg
);

  import vhd_pkg::*;

  localparam int XW      = $clog2(MAX_WIDTH + 1);
  localparam int YW      = $clog2(MAX_HEIGHT + 1);
  localparam int STRIDE  = MAX_WIDTH / 2;
  localparam int ENTRIES = (MAX_WIDTH / 2) * (MAX_HEIGHT / 2);
  localparam int AW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int QW      = $clog2(OUT_DEPTH);

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic               mode_average;
  logic [9:0]         source_width;
  logic [9:0]         source_height;
  logic [DEPTH_W-1:0] source_depth;

  assign cfg.ready = 1'b1;
  logic cfg_wr;
  assign cfg_wr = cfg.valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_average  <= 1'b0;
      source_width  <= RST_WIDTH;
      source_height <= RST_HEIGHT;
      source_depth  <= RST_DEPTH;
    end else if (cfg_wr) begin
      case (cfg.reg_index)
        REG_MODE:   mode_average  <= cfg.data[0];
        REG_WIDTH:  source_width  <= cfg.data[9:0];
        REG_HEIGHT: source_height <= cfg.data[9:0];
        REG_DEPTH:  source_depth  <= cfg.data;
        default: ;
      endcase
    end
  end

  // effective extents: zero counts as one, width/height saturate
  logic [EXT_W-1:0]   w_ext, h_ext;
  logic [XW-1:0]      w;
  logic [YW-1:0]      h;
  logic [DEPTH_W-1:0] d;

  always_comb begin
    w_ext = EXT_W'(source_width);
    if (w_ext == '0) begin
      w_ext = EXT_W'(1);
    end else if (w_ext > EXT_W'(MAX_WIDTH)) begin
      w_ext = EXT_W'(MAX_WIDTH);
    end
    h_ext = EXT_W'(source_height);
    if (h_ext == '0) begin
      h_ext = EXT_W'(1);
    end else if (h_ext > EXT_W'(MAX_HEIGHT)) begin
      h_ext = EXT_W'(MAX_HEIGHT);
    end
    w = w_ext[XW-1:0];
    h = h_ext[YW-1:0];
    d = (source_depth == '0) ? DEPTH_W'(1) : source_depth;
  end

  // ---------------------------------------------------------------------------
  // stage 0: coordinates, block decode, sum RAM read
  // ---------------------------------------------------------------------------
  logic [XW-1:0]      col;
  logic [YW-1:0]      row;
  logic [DEPTH_W-1:0] slc;

  logic               accept;
  logic [XW-1:0]      ox, ow, w_m1;
  logic [YW-1:0]      oy, oh, h_m1;
  logic [DEPTH_W-1:0] oz, od, d_m1;
  logic               in_block, even, blk_last;
  logic               emit0, wr0, final0;
  logic [AW-1:0]      addr0;

  always_comb begin
    ox   = col >> 1;
    oy   = row >> 1;
    oz   = slc >> 1;
    ow   = w >> 1;
    oh   = h >> 1;
    od   = d >> 1;
    w_m1 = w - XW'(1);
    h_m1 = h - YW'(1);
    d_m1 = d - DEPTH_W'(1);
    in_block = (ox < ow) && (oy < oh) && (oz < od);
    even     = !(col[0] | row[0] | slc[0]);
    blk_last = col[0] & row[0] & slc[0];
    addr0    = AW'(32'(oy) * STRIDE + 32'(ox));
    if (mode_average) begin
      emit0  = in_block && blk_last;
      wr0    = in_block;
      final0 = (ox == ow - XW'(1)) && (oy == oh - YW'(1)) && (oz == od - DEPTH_W'(1));
    end else begin
      emit0  = even;
      wr0    = 1'b0;
      // last even coordinate on each axis
      final0 = (col == {w_m1[XW-1:1], 1'b0}) && (row == {h_m1[YW-1:1], 1'b0})
               && (slc == {d_m1[DEPTH_W-1:1], 1'b0});
    end
  end

  // raster counters
  logic [XW-1:0]      col_inc;
  logic [YW-1:0]      row_inc;
  logic [DEPTH_W-1:0] slc_inc;
  assign col_inc = col + XW'(1);
  assign row_inc = row + YW'(1);
  assign slc_inc = slc + DEPTH_W'(1);

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      col <= '0;
      row <= '0;
      slc <= '0;
    end else if (accept) begin
      if (col_inc >= w) begin
        col <= '0;
        if (row_inc >= h) begin
          row <= '0;
          slc <= (slc_inc >= d) ? '0 : slc_inc;
        end else begin
          row <= row_inc;
        end
      end else begin
        col <= col_inc;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stage 1: sum update and write back
  // ---------------------------------------------------------------------------
  logic               s1_valid;
  logic               s1_emit, s1_wr, s1_first, s1_final, s1_avg;
  logic [VOXEL_W-1:0] s1_voxel;
  logic [AW-1:0]      s1_addr;
  logic               s1_fwd_hit;
  logic [SUM_W-1:0]   s1_fwd_data;
  logic [SUM_W-1:0]   s1_sum, ram_rdata, base;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_emit     <= emit0;
      s1_wr       <= wr0;
      s1_first    <= even;
      s1_final    <= final0;
      s1_avg      <= mode_average;
      s1_voxel    <= voxel_stream.voxel_in;
      s1_addr     <= addr0;
      // the entry written this edge is not yet in the read data
      s1_fwd_hit  <= s1_valid && s1_wr && (s1_addr == addr0);
      s1_fwd_data <= s1_sum;
    end
  end

  always_comb begin
    if (s1_first) begin
      base = '0;
    end else if (s1_fwd_hit) begin
      base = s1_fwd_data;
    end else begin
      base = ram_rdata;
    end
    s1_sum = base + SUM_W'(s1_voxel);
  end

  vhd_ram #(
    .WIDTH  (SUM_W),
    .DEPTH  (ENTRIES),
    .ADDR_W (AW)
  ) u_sums (
    .clk   (clk),
    .we    (s1_valid && s1_wr),
    .waddr (s1_addr),
    .wdata (s1_sum),
    .raddr (addr0),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // output queue: decouples the RMW pipe from output stalls
  // ---------------------------------------------------------------------------
  logic [VOXEL_W-1:0] q_voxel [OUT_DEPTH];
  logic               q_final [OUT_DEPTH];
  logic [QW-1:0]      q_wp, q_rp;
  logic [QW:0]        q_cnt;
  logic               push, pop;

  assign push = s1_valid && s1_emit;
  assign pop  = level_stream.valid && level_stream.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_wp  <= '0;
      q_rp  <= '0;
      q_cnt <= '0;
    end else begin
      if (push) q_wp <= q_wp + QW'(1);
      if (pop)  q_rp <= q_rp + QW'(1);
      q_cnt <= q_cnt + (QW+1)'(push) - (QW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_voxel[q_wp] <= s1_avg ? s1_sum[SUM_W-1:3] : s1_voxel;
      q_final[q_wp] <= s1_final;
    end
  end

  assign level_stream.valid       = (q_cnt != '0);
  assign level_stream.voxel_out   = q_voxel[q_rp];
  assign level_stream.final_voxel = q_final[q_rp];

  // room for the voxel in stage 1 and the one taken now
  assign voxel_stream.ready = ((q_cnt + (QW+1)'(s1_valid)) < (QW+1)'(OUT_DEPTH));
  assign accept = voxel_stream.valid && voxel_stream.ready;

endmodule

`default_nettype wire

// File: rtl/core/vhd_ram.sv
`default_nettype none
// -----------------------------------------------------------------------------
// vhd_ram
// Simple dual-port RAM, one write and one registered read, read-first.
// -----------------------------------------------------------------------------
module vhd_ram #(
  parameter int WIDTH  = 11,
  parameter int DEPTH  = 65536,
  parameter int ADDR_W = 16
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: rtl/core/vhd_checker.sv
`default_nettype none
// -----------------------------------------------------------------------------
// vhd_checker
// Port-level checks of the downsampler, bound to the top level.
// -----------------------------------------------------------------------------
module vhd_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_valid,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [vhd_pkg::VOXEL_W-1:0] out_voxel,
  input wire logic                        out_final
);

  // queue comes out of reset empty
  a_rst_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // a stalled output beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_voxel) && $stable(out_final))
    else $error("stalled output beat changed");

  // a beat into an empty queue comes from a source voxel taken earlier, via stage 1
  a_out_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("output beat with no source voxel");

  // input back-pressure only while output beats are waiting
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input stalled with empty output");

endmodule

bind volume_halving_downsampler_top vhd_checker u_vhd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (voxel_stream.valid),
  .in_ready  (voxel_stream.ready),
  .out_valid (level_stream.valid),
  .out_ready (level_stream.ready),
  .out_voxel (level_stream.voxel_out),
  .out_final (level_stream.final_voxel)
);

`default_nettype wire

// File: tb/tb_top.sv
// -----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the volume halving downsampler.
// A directed table covers reset defaults, clamped extents, the empty average
// level and a saturated box mean. Random volume phases follow, each with its
// own register setting. Every accepted output beat is checked against an
// in-bench model of the pick/box-mean datapath or a hand-written value, with
// random pacing on both streams and long output back-pressure stretches.
// -----------------------------------------------------------------------------
module tb_top;
  import vhd_pkg::*;

  localparam int MAX_WIDTH    = 512;
  localparam int MAX_HEIGHT   = 512;
  localparam int MAX_DEPTH    = 65535;
  localparam int SUM_STRIDE   = MAX_WIDTH / 2;
  localparam int SUM_SLOTS    = SUM_STRIDE * (MAX_HEIGHT / 2);
  localparam int RANDOM_ITEMS = 1850;
  localparam int SETTLE       = 6;     // settle wait before each register write
  localparam int DRAIN        = 20;
  localparam int HOLD_CYCLES  = 120;   // long output stall, queue is 4 deep
  localparam int STALL_LIMIT  = 4000;  // cycles without any beat on any channel

  typedef struct packed {
    logic [VOXEL_W-1:0] voxel;
    logic               final_voxel;
  } level_beat_t;

  typedef enum {PACE_FREE, PACE_SEND_IDLE, PACE_RECV_STALL, PACE_BOTH} pace_t;

  // directed rows: register write, voxel checked by the model,
  // voxel with no output, voxel with a hand-written output
  typedef enum {ROW_CFG, ROW_PRED, ROW_QUIET, ROW_EXPECT} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [CFG_DATA_W-1:0] word;
    logic [VOXEL_W-1:0]   voxel;
    logic [VOXEL_W-1:0]   want_voxel;
    bit                   want_final;
  } plan_row_t;

  localparam int PLAN_ROWS = 29;

  plan_row_t plan [PLAN_ROWS] = '{
    // reset setting: nearest, 512^3, even-x voxels pass, no final yet
    '{ROW_EXPECT, REG_MODE,   16'h0000, 8'h00, 8'h00, 1'b0},
    '{ROW_QUIET,  REG_MODE,   16'h0000, 8'hFF, 8'h00, 1'b0},
    '{ROW_EXPECT, REG_MODE,   16'h0000, 8'hFF, 8'hFF, 1'b0},
    // zero width counts as one: 1x1x1 volume, every voxel is the last
    '{ROW_CFG,    REG_WIDTH,  16'h0000, 8'h00, 8'h00, 1'b0},
    '{ROW_CFG,    REG_HEIGHT, 16'h0001, 8'h00, 8'h00, 1'b0},
    '{ROW_CFG,    REG_DEPTH,  16'h0001, 8'h00, 8'h00, 1'b0},
    '{ROW_EXPECT, REG_MODE,   16'h0000, 8'hA5, 8'hA5, 1'b1},
    '{ROW_EXPECT, REG_MODE,   16'h0000, 8'h5A, 8'h5A, 1'b1},
    // average of a 1x1x1 volume: empty level
    '{ROW_CFG,    REG_MODE,   16'h0001, 8'h00, 8'h00, 1'b0},
    '{ROW_QUIET,  REG_MODE,   16'h0000, 8'h80, 8'h00, 1'b0},
    // one full 2x2x2 block of 0xFF: sum 2040, mean 255
    '{ROW_CFG,    REG_WIDTH,  16'h0002, 8'h00, 8'h00, 1'b0},
    '{ROW_CFG,    REG_HEIGHT, 16'h0002, 8'h00, 8'h00, 1'b0},
    '{ROW_CFG,    REG_DEPTH,  16'h0002, 8'h00, 8'h00, 1'b0},
    '{ROW_QUIET,  REG_MODE,   16'h0000, 8'hFF, 8'h00, 1'b0},
    '{ROW_QUIET,  REG_MODE,   16'h0000, 8'hFF, 8'h00, 1'b0},
    '{ROW_QUIET,  REG_MODE,   16'h0000, 8'hFF, 8'h00, 1'b0},
    '{ROW_QUIET,  REG_MODE,   16'h0000, 8'hFF, 8'h00, 1'b0},
    '{ROW_QUIET,  REG_MODE,   16'h0000, 8'hFF, 8'h00, 1'b0},
    '{ROW_QUIET,  REG_MODE,   16'h0000, 8'hFF, 8'h00, 1'b0},
    '{ROW_QUIET,  REG_MODE,   16'h0000, 8'hFF, 8'h00, 1'b0},
    '{ROW_EXPECT, REG_MODE,   16'h0000, 8'hFF, 8'hFF, 1'b1},
    // counters wrapped: a second block with mixed values, truncating mean
    '{ROW_PRED,   REG_MODE,   16'h0000, 8'h01, 8'h00, 1'b0},
    '{ROW_PRED,   REG_MODE,   16'h0000, 8'h80, 8'h00, 1'b0},
    '{ROW_PRED,   REG_MODE,   16'h0000, 8'h7F, 8'h00, 1'b0},
    '{ROW_PRED,   REG_MODE,   16'h0000, 8'h33, 8'h00, 1'b0},
    '{ROW_PRED,   REG_MODE,   16'h0000, 8'hC4, 8'h00, 1'b0},
    '{ROW_PRED,   REG_MODE,   16'h0000, 8'h0E, 8'h00, 1'b0},
    '{ROW_PRED,   REG_MODE,   16'h0000, 8'h99, 8'h00, 1'b0},
    '{ROW_PRED,   REG_MODE,   16'h0000, 8'h6B, 8'h00, 1'b0}
  };

  logic clk;
  logic rst;

  vhd_voxel_if vox_ch ();
  vhd_level_if lvl_ch ();
  vhd_cfg_if   cfg_ch ();

  volume_halving_downsampler_top #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .voxel_stream (vox_ch),
    .level_stream (lvl_ch),
    .cfg          (cfg_ch)
  );

  // shadow registers and coordinate counters of the downsampler
  logic                 mode_avg;
  logic [9:0]           reg_width;
  logic [9:0]           reg_height;
  logic [DEPTH_W-1:0]   reg_depth;
  logic [8:0]           col_pos;
  logic [8:0]           row_pos;
  logic [15:0]          slice_pos;
  logic [SUM_W-1:0]     block_acc [SUM_SLOTS];

  level_beat_t level_expect[$];   // output beats still owed by the DUT
  int          errors = 0;
  int          voxels_sent = 0;
  int          quiet_cycles = 0;
  pace_t       pace = PACE_FREE;
  bit          hold_request = 1'b0;
  bit          vox_offered = 1'b0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // zero counts as one, width and height saturate
  function automatic int extent_of(input int raw, input int limit);
    if (raw == 0) return 1;
    if (raw > limit) return limit;
    return raw;
  endfunction

  function automatic void set_register(input logic [CFG_IDX_W-1:0] idx,
                                       input logic [CFG_DATA_W-1:0] word);
    case (idx)
      REG_MODE:   mode_avg   = word[0];
      REG_WIDTH:  reg_width  = word[9:0];
      REG_HEIGHT: reg_height = word[9:0];
      REG_DEPTH:  reg_depth  = word;
      default: ;
    endcase
    // any write restarts the volume
    col_pos   = '0;
    row_pos   = '0;
    slice_pos = '0;
  endfunction

  // one source voxel: even-voxel pick or 2x2x2 box mean, then advance x/y/z
  function automatic void downsample_step(input logic [VOXEL_W-1:0] v, output bit emits,
                                          output level_beat_t beat);
    int w, h, d, x, y, z, ow, oh, od, ox, oy, oz, slot;
    logic [SUM_W-1:0] acc;
    w = extent_of(int'(reg_width), MAX_WIDTH);
    h = extent_of(int'(reg_height), MAX_HEIGHT);
    d = extent_of(int'(reg_depth), MAX_DEPTH);
    x = int'(col_pos);
    y = int'(row_pos);
    z = int'(slice_pos);
    emits = 1'b0;
    beat = '0;
    if (mode_avg) begin
      ow = w / 2;
      oh = h / 2;
      od = d / 2;
      ox = x / 2;
      oy = y / 2;
      oz = z / 2;
      // trailing odd column/row/slice falls outside every block
      if (ox < ow && oy < oh && oz < od) begin
        slot = oy * SUM_STRIDE + ox;
        // first voxel of a block overwrites the stale sum
        acc = (((x | y | z) & 1) == 0) ? SUM_W'(v) : block_acc[slot] + SUM_W'(v);
        block_acc[slot] = acc;
        if ((x & y & z & 1) != 0) begin
          emits = 1'b1;
          beat.voxel = acc[SUM_W-1:3];
          beat.final_voxel = (ox == ow - 1) && (oy == oh - 1) && (oz == od - 1);
        end
      end
    end else if (((x | y | z) & 1) == 0) begin
      emits = 1'b1;
      beat.voxel = v;
      beat.final_voxel = (x == ((w + 1) / 2 - 1) * 2) && (y == ((h + 1) / 2 - 1) * 2) &&
                         (z == ((d + 1) / 2 - 1) * 2);
    end
    x++;
    if (x >= w) begin
      x = 0;
      y++;
      if (y >= h) begin
        y = 0;
        z++;
        if (z >= d) z = 0;
      end
    end
    col_pos   = 9'(x);
    row_pos   = 9'(y);
    slice_pos = 16'(z);
  endfunction

  task automatic drop_offer();
    if (vox_offered) begin
      vox_ch.valid <= 1'b0;
      vox_offered = 1'b0;
    end
  endtask

  // offer one voxel, book its expected beat once taken, then maybe idle
  task automatic send_voxel(input logic [VOXEL_W-1:0] v, input row_kind_t kind,
                            input logic [VOXEL_W-1:0] want_voxel, input bit want_final);
    bit          emits;
    level_beat_t beat;
    int          idle_pct;
    vox_ch.valid    <= 1'b1;
    vox_ch.voxel_in <= v;
    vox_offered = 1'b1;
    @(posedge clk);
    while (!vox_ch.ready) @(posedge clk);
    voxels_sent++;
    downsample_step(v, emits, beat);
    case (kind)
      ROW_PRED:   if (emits) level_expect.insert(level_expect.size(), beat);
      ROW_EXPECT: level_expect.insert(level_expect.size(),
                                      level_beat_t'{voxel: want_voxel, final_voxel: want_final});
      default: ;
    endcase
    idle_pct = (pace == PACE_SEND_IDLE) ? 67 : ((pace == PACE_BOTH) ? 25 : 0);
    while ($urandom_range(99) < idle_pct) begin
      drop_offer();
      @(posedge clk);
    end
  endtask

  // register writes only with the datapath drained
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] word);
    drop_offer();
    while (level_expect.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.data      <= word;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    set_register(idx, word);
  endtask

  // output side: free, random stall, or one long hold on request
  initial begin : level_sink
    int k;
    lvl_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        lvl_ch.ready <= 1'b0;
        for (k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
      end
      if (pace == PACE_RECV_STALL)
        lvl_ch.ready <= ($urandom_range(99) >= 67);
      else if (pace == PACE_BOTH)
        lvl_ch.ready <= ($urandom_range(99) >= 25);
      else
        lvl_ch.ready <= 1'b1;
    end
  end

  // scoreboard: each accepted output beat against the oldest expectation
  always @(posedge clk) begin : level_check
    level_beat_t want;
    if (!rst && lvl_ch.valid && lvl_ch.ready) begin
      if (level_expect.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got voxel_out=%h final_voxel=%b",
                 $time, lvl_ch.voxel_out, lvl_ch.final_voxel);
        errors++;
      end else begin
        want = level_expect[0];
        level_expect.delete(0);
        if (lvl_ch.voxel_out !== want.voxel) begin
          $display("%0t: voxel_out mismatch, expected %h, got %h",
                   $time, want.voxel, lvl_ch.voxel_out);
          errors++;
        end
        if (lvl_ch.final_voxel !== want.final_voxel) begin
          $display("%0t: final_voxel mismatch, expected %b, got %b",
                   $time, want.final_voxel, lvl_ch.final_voxel);
          errors++;
        end
      end
    end
  end

  // watchdog: nothing moving on any channel for too long
  always @(posedge clk) begin
    if ((vox_ch.valid && vox_ch.ready) || (lvl_ch.valid && lvl_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

  initial begin : stimulus
    int                    n, vol, cap, w_val, h_val, d_val;
    bit                    avg, squeeze;
    logic [CFG_DATA_W-1:0] word;
    logic [VOXEL_W-1:0]    v;

    rst              <= 1'b1;
    vox_ch.valid     <= 1'b0;
    vox_ch.voxel_in  <= '0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.reg_index <= REG_MODE;
    cfg_ch.data      <= '0;
    mode_avg   = 1'b0;
    reg_width  = RST_WIDTH;
    reg_height = RST_HEIGHT;
    reg_depth  = RST_DEPTH;
    col_pos    = '0;
    row_pos    = '0;
    slice_pos  = '0;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG)
        write_reg(plan[i].reg_index, plan[i].word);
      else
        send_voxel(plan[i].voxel, plan[i].kind, plan[i].want_voxel, plan[i].want_final);
    end

    // random phases: new setting, whole volumes with random content,
    // sometimes a volume cut short by the next setting
    for (int p = 0; voxels_sent < PLAN_ROWS + RANDOM_ITEMS; p++) begin
      pace  = pace_t'(p % 4);
      avg   = 1'($urandom_range(1));
      w_val = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 8);
      h_val = $urandom_range(0, 6);
      d_val = $urandom_range(0, 5);
      cap   = 400;
      if (p == 0) begin
        // width above the limit saturates: a full 512-wide line
        avg = 1'b0; w_val = 1023; h_val = 0; d_val = 1; cap = 600;
      end else if (p == 1) begin
        avg = 1'b1; w_val = 3; h_val = 2; d_val = MAX_DEPTH; cap = 60;
      end else begin
        case ($urandom_range(11))
          0: begin
            case ($urandom_range(3))
              0: w_val = MAX_WIDTH;
              1: w_val = 1023;
              2: w_val = $urandom_range(MAX_WIDTH + 1, 1023);
              default: w_val = $urandom_range(64, MAX_WIDTH - 1);
            endcase
            h_val = $urandom_range(0, 2);
            d_val = $urandom_range(1, 2);
            cap = 600;
          end
          1: begin
            case ($urandom_range(3))
              0: h_val = MAX_HEIGHT;
              1: h_val = 1023;
              2: h_val = $urandom_range(MAX_HEIGHT + 1, 1023);
              default: h_val = $urandom_range(64, MAX_HEIGHT - 1);
            endcase
            w_val = $urandom_range(0, 2);
            d_val = $urandom_range(1, 2);
            cap = 600;
          end
          2: begin
            d_val = $urandom_range(1) ? MAX_DEPTH : $urandom_range(6, MAX_DEPTH - 1);
            w_val = $urandom_range(1, 4);
            h_val = $urandom_range(1, 4);
            cap = 150;
          end
          default: ;
        endcase
      end

      // unused upper bits of the data word carry junk: always for mode, half the time for width and height
      word = 16'($urandom);
      word[0] = avg;
      write_reg(REG_MODE, word);
      word = 16'($urandom);
      word[9:0] = w_val[9:0];
      if ($urandom_range(1)) word[15:10] = '0;
      write_reg(REG_WIDTH, word);
      word = 16'($urandom);
      word[9:0] = h_val[9:0];
      if ($urandom_range(1)) word[15:10] = '0;
      write_reg(REG_HEIGHT, word);
      write_reg(REG_DEPTH, 16'(d_val));

      vol = extent_of(int'(reg_width), MAX_WIDTH) * extent_of(int'(reg_height), MAX_HEIGHT) *
            extent_of(int'(reg_depth), MAX_DEPTH);
      n = vol * $urandom_range(1, 3);
      if ($urandom_range(3) == 0) n += $urandom_range(1, vol);
      if (n > cap) n = cap;
      if (n > PLAN_ROWS + RANDOM_ITEMS - voxels_sent) n = PLAN_ROWS + RANDOM_ITEMS - voxels_sent;

      // free-running phases: hold the output mid-phase
      squeeze = (p % 4 == 0);
      for (int k = 0; k < n; k++) begin
        case ($urandom_range(7))
          0: v = 8'h00;
          1: v = 8'hFF;
          default: v = 8'($urandom);
        endcase
        if (squeeze && k == n / 2) hold_request = 1'b1;
        send_voxel(v, ROW_PRED, '0, 1'b0);
      end
    end

    drop_offer();
    while (level_expect.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    if (errors == 0)
      $display("tb_top: done, clean");
    else
      $display("tb_top: done, errors");
    $finish;
  end

endmodule
